/* rtl/qjts_pkg.sv */
// qjts_pkg: shared types and constants of the quintic joint trajectory sampler.
// Holds the command/result word structs, config struct, register map, sequencer
// states and the polynomial term table. No dependencies.
package qjts_pkg;

  localparam int ADDR_W    = 4;
  localparam int MUL_A_W   = 35;
  localparam int MUL_B_W   = 32;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int DIV_NUM_W = 64;
  localparam int DIV_DEN_W = 48;
  localparam int DIV_Q_W   = 32;

  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  typedef struct packed {
    logic               mode;
    logic [2:0]         joint_index;
    logic signed [23:0] start_position;
    logic signed [23:0] goal_position;
    logic [15:0]        step_index;
  } cmd_word_t;

  typedef struct packed {
    logic [2:0]         joint_number;
    logic signed [23:0] position;
    logic signed [23:0] velocity;
    logic signed [23:0] acceleration;
    logic [23:0]        waypoint_time;
    logic [15:0]        point_count;
    logic               last;
  } result_word_t;

  typedef struct packed {
    logic [15:0] step_period;
    logic [23:0] min_duration;
    logic [19:0] inverse_speed;
    logic [3:0]  joint_count;
  } cfg_t;

  typedef enum logic [1:0] {
    REG_STEP_PERIOD,
    REG_MIN_DURATION,
    REG_INVERSE_SPEED,
    REG_JOINT_COUNT
  } reg_idx_t;

  localparam logic [15:0] RST_STEP_PERIOD   = 16'd3277;
  localparam logic [23:0] RST_MIN_DURATION  = 24'd131072;
  localparam logic [19:0] RST_INVERSE_SPEED = 20'd163840;
  localparam logic [3:0]  RST_JOINT_COUNT   = 4'd6;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MAX_RD,
    ST_MAX_CMP,
    ST_DUR_MUL,
    ST_DUR_GET,
    ST_DSQ_MUL,
    ST_DSQ_GET,
    ST_T_MUL,
    ST_T_GET,
    ST_PC_WAIT,
    ST_TAU_DIV,
    ST_TAU_WAIT,
    ST_POW_MUL,
    ST_POW_GET,
    ST_POLY_MUL,
    ST_POLY_ADD,
    ST_J_RD,
    ST_J_POS_MUL,
    ST_J_POS,
    ST_J_VEL_DIV,
    ST_J_VEL_WAIT,
    ST_J_ACC_MUL,
    ST_J_ACC_DIV,
    ST_J_ACC_WAIT,
    ST_J_OUT
  } seq_state_t;

  // powers of tau, Q1.30
  localparam logic [2:0] POW_TAU = 3'd1;
  localparam logic [2:0] POW_A2  = 3'd2;
  localparam logic [2:0] POW_A3  = 3'd3;
  localparam logic [2:0] POW_A4  = 3'd4;
  localparam logic [2:0] POW_A5  = 3'd5;

  typedef enum logic [1:0] {
    DST_S,
    DST_DS,
    DST_DDS
  } poly_dst_t;

  typedef struct packed {
    poly_dst_t         dst;
    logic [2:0]        pw;
    logic signed [8:0] coef;
  } poly_term_t;

  localparam logic [3:0] POLY_LAST = 4'd8;

  // s = 10a3 - 15a4 + 6a5, s' = 30a2 - 60a3 + 30a4, s'' = 60tau - 180a2 + 120a3
  function automatic poly_term_t poly_term(input logic [3:0] k);
    poly_term_t r;
    case (k)
      4'd0:    r = '{DST_S,   POW_A3,  9'sd10};
      4'd1:    r = '{DST_S,   POW_A4, -9'sd15};
      4'd2:    r = '{DST_S,   POW_A5,  9'sd6};
      4'd3:    r = '{DST_DS,  POW_A2,  9'sd30};
      4'd4:    r = '{DST_DS,  POW_A3, -9'sd60};
      4'd5:    r = '{DST_DS,  POW_A4,  9'sd30};
      4'd6:    r = '{DST_DDS, POW_TAU, 9'sd60};
      4'd7:    r = '{DST_DDS, POW_A2, -9'sd180};
      4'd8:    r = '{DST_DDS, POW_A3,  9'sd120};
      default: r = '{DST_S,   POW_TAU, 9'sd0};
    endcase
    return r;
  endfunction

endpackage

/* rtl/quintic_joint_trajectory_sampler.sv */
// Quintic joint trajectory sampler, top level: sequencer, joint angle store,
// shared multiplier and divider. Depends on qjts_pkg, qjts_regs, qjts_mul, qjts_div.
//
// A load word (mode 0) stores one joint's start and goal angle in the same cycle it
// is taken and keeps busy low. A sample word (mode 1) raises busy and runs a
// sequencer over one shared 35x32 multiplier and one 32-step restoring divider:
// largest joint move, duration, duration squared, waypoint time, point count and
// tau (two divisions, the tau one skipped at zero duration), four powers of tau and
// nine polynomial terms, then for each joint in use the position product and two
// rounded divisions for velocity and acceleration (skipped at zero duration).
// Each joint's result word appears for exactly one cycle with result_valid; the
// receiver cannot stall and must take it. last marks the final joint's word and
// busy drops in the following cycle. The user must see that configuration is
// written through the APB port only while busy is low; the block does not enforce
// it. Reading a joint never loaded gives undefined data.
module quintic_joint_trajectory_sampler import qjts_pkg::*; #(
  parameter int MAX_JOINTS = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              start,
  output logic              busy,
  input  cmd_word_t         command,
  output logic              result_valid,
  output result_word_t      result
);

  localparam int JW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
  localparam int NW = $clog2(MAX_JOINTS + 1);

  cfg_t       cfg;
  seq_state_t state, state_next;

  // joint angle store
  logic signed [23:0] start_mem [MAX_JOINTS];
  logic signed [23:0] goal_mem  [MAX_JOINTS];
  logic signed [23:0] rd_start, rd_goal;

  logic [NW-1:0] n_use, j;
  logic          j_last;
  logic [15:0]   per, step_r, pc;
  logic [24:0]   maxd;
  logic [23:0]   dur, t_r;
  logic [47:0]   dsq;
  logic [30:0]   tau, a2, a3, a4, a5;
  logic [30:0]   pow_prev, pow_term;
  logic [2:0]    pk;
  logic [3:0]    tk;
  poly_term_t    term;
  logic signed [39:0] s_acc, ds_acc, dds_acc;
  logic               p_neg;
  logic signed [23:0] pos_r, vel_r, acc_r;

  logic signed [24:0] delta;
  logic [24:0]        delta_mag;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p;
  logic                      prod_neg;
  logic [60:0]               prod_mag;

  logic                 div_start, div_ovf, div_done;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic [DIV_Q_W-1:0]   div_q;

  logic [45:0] dur_round;
  logic [25:0] dur_raw;
  logic [23:0] dur_sat, dur_calc;
  logic [27:0] pos_q;
  logic signed [29:0] pos_off, pos_sum;

  function automatic logic signed [23:0] sat30(input logic signed [29:0] v);
    logic signed [23:0] r;
    if (v > 30'sd8388607)       r = 24'sh7FFFFF;
    else if (v < -30'sd8388608) r = 24'sh800000;
    else                        r = v[23:0];
    return r;
  endfunction

  // signed, saturated result of a magnitude division
  function automatic logic signed [23:0] sat_div(input logic neg, input logic ovf,
                                                input logic [31:0] q);
    logic signed [23:0] r;
    if (!neg) r = (ovf || q > 32'd8388607) ? 24'sh7FFFFF : q[23:0];
    else      r = (ovf || q >= 32'd8388608) ? 24'sh800000 : -q[23:0];
    return r;
  endfunction

  qjts_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  qjts_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  qjts_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .q     (div_q),
    .ovf   (div_ovf),
    .done  (div_done)
  );

  // joints in use: zero acts as one, large values clamp to the store depth
  always_comb begin
    if (cfg.joint_count == '0)                   n_use = NW'(1);
    else if (int'(cfg.joint_count) > MAX_JOINTS) n_use = NW'(MAX_JOINTS);
    else                                         n_use = NW'(cfg.joint_count);
  end

  assign per    = (cfg.step_period == '0) ? 16'd1 : cfg.step_period;
  assign j_last = (j + NW'(1)) == n_use;

  // angle store: written by load words, read at the joint counter
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start && command.mode == MODE_LOAD &&
        int'(command.joint_index) < MAX_JOINTS) begin
      start_mem[JW'(command.joint_index)] <= command.start_position;
      goal_mem[JW'(command.joint_index)]  <= command.goal_position;
    end
    rd_start <= start_mem[j[JW-1:0]];
    rd_goal  <= goal_mem[j[JW-1:0]];
  end

  assign delta     = {rd_goal[23], rd_goal} - {rd_start[23], rd_start};
  assign delta_mag = delta[24] ? 25'(-delta) : 25'(delta);

  assign prod_neg = mul_p[MUL_P_W-1];
  assign prod_mag = prod_neg ? 61'(-mul_p) : 61'(mul_p);

  // duration = round(M * inverse_speed / 2^20), saturated, floored at min_duration
  assign dur_round = mul_p[45:0] + 46'h80000;
  assign dur_raw   = dur_round[45:20];
  assign dur_sat   = (dur_raw > 26'hFFFFFF) ? 24'hFFFFFF : dur_raw[23:0];
  assign dur_calc  = (dur_sat < cfg.min_duration) ? cfg.min_duration : dur_sat;

  // position: start + s*delta / 2^30, rounded half away from zero
  assign pos_q   = 28'((prod_mag + 61'h20000000) >> 30);
  assign pos_off = prod_neg ? -$signed({2'b00, pos_q}) : $signed({2'b00, pos_q});
  assign pos_sum = $signed({{6{rd_start[23]}}, rd_start}) + pos_off;

  assign term = poly_term(tk);

  always_comb begin
    case (pk)
      POW_A2:  pow_prev = tau;
      POW_A3:  pow_prev = a2;
      POW_A4:  pow_prev = a3;
      POW_A5:  pow_prev = a4;
      default: pow_prev = tau;
    endcase
    case (term.pw)
      POW_TAU: pow_term = tau;
      POW_A2:  pow_term = a2;
      POW_A3:  pow_term = a3;
      POW_A4:  pow_term = a4;
      POW_A5:  pow_term = a5;
      default: pow_term = tau;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:       if (start && command.mode == MODE_SAMPLE) state_next = ST_MAX_RD;
      ST_MAX_RD:     state_next = ST_MAX_CMP;
      ST_MAX_CMP:    state_next = j_last ? ST_DUR_MUL : ST_MAX_RD;
      ST_DUR_MUL:    state_next = ST_DUR_GET;
      ST_DUR_GET:    state_next = ST_DSQ_MUL;
      ST_DSQ_MUL:    state_next = ST_DSQ_GET;
      ST_DSQ_GET:    state_next = ST_T_MUL;
      ST_T_MUL:      state_next = ST_T_GET;
      ST_T_GET:      state_next = ST_PC_WAIT;
      ST_PC_WAIT:    if (div_done) state_next = ST_TAU_DIV;
      ST_TAU_DIV:    state_next = (dur == '0) ? ST_POW_MUL : ST_TAU_WAIT;
      ST_TAU_WAIT:   if (div_done) state_next = ST_POW_MUL;
      ST_POW_MUL:    state_next = ST_POW_GET;
      ST_POW_GET:    state_next = (pk == POW_A5) ? ST_POLY_MUL : ST_POW_MUL;
      ST_POLY_MUL:   state_next = ST_POLY_ADD;
      ST_POLY_ADD:   state_next = (tk == POLY_LAST) ? ST_J_RD : ST_POLY_MUL;
      ST_J_RD:       state_next = ST_J_POS_MUL;
      ST_J_POS_MUL:  state_next = ST_J_POS;
      ST_J_POS:      state_next = (dur == '0) ? ST_J_OUT : ST_J_VEL_DIV;
      ST_J_VEL_DIV:  state_next = ST_J_VEL_WAIT;
      ST_J_VEL_WAIT: if (div_done) state_next = ST_J_ACC_MUL;
      ST_J_ACC_MUL:  state_next = ST_J_ACC_DIV;
      ST_J_ACC_DIV:  state_next = ST_J_ACC_WAIT;
      ST_J_ACC_WAIT: if (div_done) state_next = ST_J_OUT;
      ST_J_OUT:      state_next = j_last ? ST_IDLE : ST_J_RD;
      default:       state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer: handshake, multiplier and divider operands
  always_comb begin
    busy         = state != ST_IDLE;
    result_valid = state == ST_J_OUT;
    mul_a        = '0;
    mul_b        = '0;
    div_start    = 1'b0;
    div_num      = '0;
    div_den      = '0;
    unique case (state)
      ST_DUR_MUL: begin
        mul_a = MUL_A_W'(maxd);
        mul_b = MUL_B_W'(cfg.inverse_speed);
      end
      ST_DSQ_MUL: begin
        mul_a     = MUL_A_W'(dur);
        mul_b     = MUL_B_W'(dur);
        // point count = ceil(dur / per)
        div_start = 1'b1;
        div_num   = DIV_NUM_W'(dur) + DIV_NUM_W'(per) - DIV_NUM_W'(1);
        div_den   = DIV_DEN_W'(per);
      end
      ST_T_MUL: begin
        mul_a = MUL_A_W'(step_r);
        mul_b = MUL_B_W'(per);
      end
      ST_TAU_DIV: begin
        div_start = dur != '0;
        div_num   = {10'b0, t_r, 30'b0};
        div_den   = DIV_DEN_W'(dur);
      end
      ST_POW_MUL: begin
        mul_a = MUL_A_W'(pow_prev);
        mul_b = MUL_B_W'(tau);
      end
      ST_POLY_MUL: begin
        mul_a = {{(MUL_A_W-9){term.coef[8]}}, term.coef};
        mul_b = MUL_B_W'(pow_term);
      end
      ST_J_POS_MUL: begin
        mul_a = s_acc[MUL_A_W-1:0];
        mul_b = {{(MUL_B_W-25){delta[24]}}, delta};
      end
      ST_J_POS: begin
        mul_a = ds_acc[MUL_A_W-1:0];
        mul_b = {{(MUL_B_W-25){delta[24]}}, delta};
      end
      ST_J_VEL_DIV: begin
        // |s' d| / (dur << 14), half added for rounding
        div_start = 1'b1;
        div_num   = DIV_NUM_W'(prod_mag) + (DIV_NUM_W'(dur) << 13);
        div_den   = DIV_DEN_W'(dur) << 14;
      end
      ST_J_ACC_MUL: begin
        mul_a = dds_acc[MUL_A_W-1:0];
        mul_b = {{(MUL_B_W-27){delta[24]}}, delta, 2'b00};
      end
      ST_J_ACC_DIV: begin
        // |4 s'' d| / dur^2
        div_start = 1'b1;
        div_num   = DIV_NUM_W'(prod_mag) + DIV_NUM_W'(dsq >> 1);
        div_den   = dsq;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          j      <= '0;
          maxd   <= '0;
          step_r <= command.step_index;
        end
      end
      ST_MAX_CMP: begin
        if (delta_mag > maxd) maxd <= delta_mag;
        j <= j + NW'(1);
      end
      ST_DUR_GET: dur <= dur_calc;
      ST_DSQ_GET: dsq <= mul_p[47:0];
      ST_T_GET:   t_r <= (mul_p[31:0] > 32'(dur)) ? dur : mul_p[23:0];
      ST_PC_WAIT: begin
        if (div_done) pc <= (div_ovf || div_q > 32'hFFFF) ? 16'hFFFF : div_q[15:0];
      end
      ST_TAU_DIV: begin
        pk <= POW_A2;
        // zero duration: tau taken as one
        if (dur == '0) tau <= 31'h40000000;
      end
      ST_TAU_WAIT: if (div_done) tau <= div_q[30:0];
      ST_POW_GET: begin
        case (pk)
          POW_A2:  a2 <= mul_p[60:30];
          POW_A3:  a3 <= mul_p[60:30];
          POW_A4:  a4 <= mul_p[60:30];
          POW_A5:  a5 <= mul_p[60:30];
          default: ;
        endcase
        pk <= pk + 3'd1;
        if (pk == POW_A5) begin
          tk      <= '0;
          s_acc   <= '0;
          ds_acc  <= '0;
          dds_acc <= '0;
        end
      end
      ST_POLY_ADD: begin
        case (term.dst)
          DST_S:   s_acc   <= s_acc + mul_p[39:0];
          DST_DS:  ds_acc  <= ds_acc + mul_p[39:0];
          DST_DDS: dds_acc <= dds_acc + mul_p[39:0];
          default: ;
        endcase
        tk <= tk + 4'd1;
        if (tk == POLY_LAST) j <= '0;
      end
      ST_J_POS: begin
        pos_r <= sat30(pos_sum);
        if (dur == '0) begin
          vel_r <= '0;
          acc_r <= '0;
        end
      end
      ST_J_VEL_DIV:  p_neg <= prod_neg;
      ST_J_VEL_WAIT: if (div_done) vel_r <= sat_div(p_neg, div_ovf, div_q);
      ST_J_ACC_DIV:  p_neg <= prod_neg;
      ST_J_ACC_WAIT: if (div_done) acc_r <= sat_div(p_neg, div_ovf, div_q);
      ST_J_OUT:      j <= j + NW'(1);
      default: ;
    endcase
  end

  // result word, shown while result_valid is high
  assign result.joint_number  = 3'(j);
  assign result.position      = pos_r;
  assign result.velocity      = vel_r;
  assign result.acceleration  = acc_r;
  assign result.waypoint_time = t_r;
  assign result.point_count   = pc;
  assign result.last          = j_last;

endmodule

/* rtl/qjts_regs.sv */
// qjts_regs: APB-style configuration registers of the trajectory sampler.
// Depends on qjts_pkg (cfg_t, register map, reset values).
module qjts_regs import qjts_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_period   <= RST_STEP_PERIOD;
      cfg.min_duration  <= RST_MIN_DURATION;
      cfg.inverse_speed <= RST_INVERSE_SPEED;
      cfg.joint_count   <= RST_JOINT_COUNT;
    end else if (wr) begin
      unique case (idx)
        REG_STEP_PERIOD:   cfg.step_period   <= pwdata[15:0];
        REG_MIN_DURATION:  cfg.min_duration  <= pwdata[23:0];
        REG_INVERSE_SPEED: cfg.inverse_speed <= pwdata[19:0];
        REG_JOINT_COUNT:   cfg.joint_count   <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_STEP_PERIOD:   prdata = 32'(cfg.step_period);
      REG_MIN_DURATION:  prdata = 32'(cfg.min_duration);
      REG_INVERSE_SPEED: prdata = 32'(cfg.inverse_speed);
      REG_JOINT_COUNT:   prdata = 32'(cfg.joint_count);
      default:           prdata = '0;
    endcase
  end

endmodule

/* rtl/qjts_mul.sv */
// qjts_mul: shared signed multiplier with registered product.
// Depends on qjts_pkg (operand widths).
module qjts_mul import qjts_pkg::*; (
  input  logic                      clk,
  input  logic signed [MUL_A_W-1:0] a,
  input  logic signed [MUL_B_W-1:0] b,
  output logic signed [MUL_P_W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= MUL_P_W'(a) * MUL_P_W'(b);
  end

endmodule

/* rtl/qjts_div.sv */
// qjts_div: restoring divider, one quotient bit per cycle, 32 quotient bits.
// Flags overflow when the quotient does not fit. Depends on qjts_pkg.
module qjts_div import qjts_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [DIV_DEN_W-1:0] den,
  output logic [DIV_Q_W-1:0]   q,
  output logic                 ovf,
  output logic                 done
);

  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] den_r;
  logic [DIV_Q_W-1:0]   nsh;
  logic [5:0]           cnt;
  logic                 run;
  logic [DIV_DEN_W:0]   trial;
  logic                 fits;

  assign trial = {rem, nsh[DIV_Q_W-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      run  <= 1'b1;
      done <= 1'b0;
    end else if (run) begin
      if (cnt == 6'd1) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= DIV_DEN_W'(num[DIV_NUM_W-1:DIV_Q_W]);
      nsh   <= num[DIV_Q_W-1:0];
      den_r <= den;
      q     <= '0;
      cnt   <= 6'(DIV_Q_W);
      ovf   <= DIV_DEN_W'(num[DIV_NUM_W-1:DIV_Q_W]) >= den;
    end else if (run) begin
      rem <= fits ? DIV_DEN_W'(trial - {1'b0, den_r}) : trial[DIV_DEN_W-1:0];
      nsh <= {nsh[DIV_Q_W-2:0], 1'b0};
      q   <= {q[DIV_Q_W-2:0], fits};
      cnt <= cnt - 6'd1;
    end
  end

endmodule

/* rtl/qjts_check.sv */
// qjts_check: port-level assertions for the trajectory sampler, bound to the top.
// Depends on qjts_pkg and quintic_joint_trajectory_sampler.
module qjts_check import qjts_pkg::*; (
  input logic         clk,
  input logic         rst,
  input logic         start,
  input logic         busy,
  input cmd_word_t    command,
  input logic         result_valid,
  input result_word_t result
);

  a_valid_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> busy)
    else $error("result word outside a sample");

  a_sample_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && command.mode == MODE_SAMPLE) |=> busy)
    else $error("sample word did not start work");

  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && command.mode == MODE_LOAD) |=> !busy)
    else $error("load word made the block busy");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.last) |=> (!busy && !result_valid))
    else $error("block still busy after last joint");

  a_reset: assert property (@(posedge clk)
    rst |=> (!busy && !result_valid))
    else $error("reset did not idle the block");

endmodule

bind quintic_joint_trajectory_sampler qjts_check u_qjts_check (.*);

/* bench/qjts_checker.sv */
// qjts_checker: watches the command, result and APB channels of the trajectory
// sampler, predicts every result word and compares it with the word that comes out.
// Depends on qjts_pkg.
module qjts_checker import qjts_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  input  logic              pready,
  input  logic              start,
  input  logic              busy,
  input  cmd_word_t         command,
  input  logic              result_valid,
  input  result_word_t      result,
  output int                fail_count,
  output int                pending
);

  logic signed [23:0] start_ang [8];
  logic signed [23:0] goal_ang [8];
  logic [15:0] step_period;
  logic [23:0] min_duration;
  logic [19:0] inverse_speed;
  logic [3:0]  joint_count;
  result_word_t waypoint_q [$];

  assign pending = waypoint_q.size();

  function automatic logic signed [23:0] clip24(input longint v);
    if (v > 64'sd8388607) return 24'sh7FFFFF;
    if (v < -64'sd8388608) return 24'sh800000;
    return v[23:0];
  endfunction

  // half away from zero, magnitude capped at 2^40
  function automatic longint div_half_away(input longint num, input longint unsigned den);
    longint unsigned mag;
    longint unsigned q;
    mag = (num < 0) ? longint'(-num) : num;
    q = (mag + den / 2) / den;
    if (q > (64'd1 << 40)) q = 64'd1 << 40;
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  task automatic predict_waypoint(input logic [15:0] step);
    longint unsigned n, per, maxd, mag, dur, pc, t, tau, a2, a3, a4, a5;
    longint s, ds, dds, st, d;
    result_word_t w;
    n = (joint_count == 0) ? 1 : ((joint_count > 8) ? 8 : joint_count);
    per = (step_period == 0) ? 1 : step_period;
    maxd = 0;
    for (int i = 0; i < n; i++) begin
      d = longint'(goal_ang[i]) - longint'(start_ang[i]);
      mag = (d < 0) ? -d : d;
      if (mag > maxd) maxd = mag;
    end
    dur = (maxd * inverse_speed + (64'd1 << 19)) >> 20;
    if (dur > 64'hFFFFFF) dur = 64'hFFFFFF;
    if (dur < min_duration) dur = min_duration;
    pc = (dur + per - 1) / per;
    if (pc > 64'hFFFF) pc = 64'hFFFF;
    t = step * per;
    if (t > dur) t = dur;
    tau = (dur != 0) ? (t << 30) / dur : (64'd1 << 30);
    a2 = (tau * tau) >> 30;
    a3 = (a2 * tau) >> 30;
    a4 = (a3 * tau) >> 30;
    a5 = (a4 * tau) >> 30;
    s   = 10 * longint'(a3) - 15 * longint'(a4) + 6 * longint'(a5);
    ds  = 30 * longint'(a2) - 60 * longint'(a3) + 30 * longint'(a4);
    dds = 60 * longint'(tau) - 180 * longint'(a2) + 120 * longint'(a3);
    for (int i = 0; i < n; i++) begin
      st = longint'(start_ang[i]);
      d = longint'(goal_ang[i]) - st;
      w.joint_number = i[2:0];
      w.position = clip24(st + div_half_away(s * d, 64'd1 << 30));
      w.velocity = '0;
      w.acceleration = '0;
      if (dur != 0) begin
        w.velocity = clip24(div_half_away(ds * d, dur << 14));
        w.acceleration = clip24(div_half_away(dds * d * 4, dur * dur));
      end
      w.waypoint_time = t[23:0];
      w.point_count = pc[15:0];
      w.last = (i + 1 == n);
      waypoint_q.insert(waypoint_q.size(), w);
    end
  endtask

  always @(posedge clk) begin
    result_word_t want;
    if (rst) begin
      step_period <= RST_STEP_PERIOD;
      min_duration <= RST_MIN_DURATION;
      inverse_speed <= RST_INVERSE_SPEED;
      joint_count <= RST_JOINT_COUNT;
      waypoint_q.delete();
      fail_count <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[3:2]))
          REG_STEP_PERIOD:   step_period <= pwdata[15:0];
          REG_MIN_DURATION:  min_duration <= pwdata[23:0];
          REG_INVERSE_SPEED: inverse_speed <= pwdata[19:0];
          REG_JOINT_COUNT:   joint_count <= pwdata[3:0];
          default: ;
        endcase
      end
      if (result_valid) begin
        if (waypoint_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result word %p", result);
          fail_count <= fail_count + 1;
        end else begin
          want = waypoint_q.pop_front();
          if (result !== want) begin
            if (fail_count < 10) $display("mismatch: expected %p got %p", want, result);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy) begin
        if (command.mode == MODE_LOAD) begin
          start_ang[command.joint_index] = command.start_position;
          goal_ang[command.joint_index] = command.goal_position;
        end else begin
          predict_waypoint(command.step_index);
        end
      end
    end
  end

endmodule

/* bench/tb.sv */
// tb: stimulus and verdict for the quintic joint trajectory sampler.
// Depends on qjts_pkg, quintic_joint_trajectory_sampler and qjts_checker.
module tb import qjts_pkg::*;;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic start = 1'b0;
  logic busy;
  cmd_word_t command = '0;
  logic result_valid;
  result_word_t result;
  int fail_count, pending;
  int quiet_cycles = 0;
  bit no_gaps = 1'b0;

  localparam int WATCHDOG_LIMIT = 5000;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  quintic_joint_trajectory_sampler u_dut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .start, .busy, .command, .result_valid, .result
  );

  qjts_checker u_chk (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .start, .busy, .command, .result_valid, .result, .fail_count, .pending
  );

  // Watchdog: cycles where neither a command word nor a result word moves.
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Offer one word; start stays high into the next word unless a gap is drawn.
  task automatic send_word(input cmd_word_t w);
    int gap;
    if (!no_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 19);
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    command <= w;
    while (busy) @(negedge clk);
    // busy low here, so the word goes in at the coming rising edge
    @(negedge clk);
  endtask

  task automatic load_joint(input logic [2:0] j, input logic [23:0] a, input logic [23:0] b);
    cmd_word_t w;
    w = '0;
    w.mode = MODE_LOAD;
    w.joint_index = j;
    w.start_position = a;
    w.goal_position = b;
    w.step_index = 16'($urandom);
    send_word(w);
  endtask

  task automatic sample_at(input logic [15:0] step);
    cmd_word_t w;
    w = '0;
    w.joint_index = 3'($urandom);
    w.start_position = 24'($urandom);
    w.goal_position = 24'($urandom);
    w.mode = MODE_SAMPLE;
    w.step_index = step;
    send_word(w);
  endtask

  // Drain: all expected words back and the sequencer idle before a register write.
  task automatic wait_drained();
    start <= 1'b0;
    @(negedge clk);
    while (pending != 0 || busy) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic apb_write(input reg_idx_t idx, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(idx) << 2;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    while (!pready) @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_config(input logic [15:0] sp, input logic [23:0] md,
                            input logic [19:0] inv, input logic [3:0] jc);
    wait_drained();
    apb_write(REG_STEP_PERIOD, {16'($urandom), sp});
    apb_write(REG_MIN_DURATION, {8'($urandom), md});
    apb_write(REG_INVERSE_SPEED, {12'($urandom), inv});
    apb_write(REG_JOINT_COUNT, {28'($urandom), jc});
  endtask

  // Random traffic: half loads, half samples; loads often carry small moves so
  // the duration is not always pinned at saturation.
  task automatic random_words(input int count);
    logic [23:0] a, b;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 1) == 0) begin
        a = 24'($urandom);
        case ($urandom_range(0, 2))
          0: b = 24'($urandom);
          1: b = a + 24'($urandom_range(0, 4095)) - 24'd2048;
          default: b = a + 24'($urandom_range(0, 1 << 20)) - 24'(1 << 19);
        endcase
        load_joint(3'($urandom_range(0, 7)), a, b);
      end else if ($urandom_range(0, 5) == 0) begin
        sample_at(16'($urandom));
      end else begin
        sample_at(16'($urandom_range(0, 70)));
      end
    end
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed, reset configuration: every joint written before any sample,
    // extreme angles and full-range moves in both directions.
    load_joint(3'd0, 24'h800000, 24'h7FFFFF);
    load_joint(3'd1, 24'h7FFFFF, 24'h800000);
    load_joint(3'd2, 24'h000000, 24'h000000);
    load_joint(3'd3, 24'h123456, 24'hFEDCBA);
    load_joint(3'd4, 24'hFFFFFF, 24'h000001);
    load_joint(3'd5, 24'h055555, 24'h0AAAAA);
    load_joint(3'd6, 24'h7FFFFF, 24'h7FFFFF);
    load_joint(3'd7, 24'h800000, 24'h000000);
    sample_at(16'd0);
    sample_at(16'd1);
    sample_at(16'd20);
    sample_at(16'd65535);
    // small moves, so the minimum duration governs
    load_joint(3'd0, 24'h000100, 24'h000200);
    load_joint(3'd1, 24'h000000, 24'hFFFF00);
    for (int j = 2; j < 8; j++) load_joint(3'(j), 24'h001000, 24'h001000);
    sample_at(16'd10);
    sample_at(16'd40);
    random_words(30);

    // Zero duration: no minimum, every joint at rest; joint count 0 acts as 1,
    // step period 0 acts as 1.
    set_config(16'd0, 24'd0, 20'd163840, 4'd0);
    for (int j = 0; j < 8; j++) load_joint(3'(j), 24'h2AAAAA, 24'h2AAAAA);
    sample_at(16'd0);
    sample_at(16'd5);
    random_words(25);

    // Finest step, no minimum, slowest-to-fastest speed extreme, all joints.
    set_config(16'd1, 24'd0, 20'd1, 4'd8);
    random_words(30);

    // Upper extremes; joint count above the store acts as eight.
    set_config(16'd65535, 24'hFFFFFF, 20'hFFFFF, 4'd15);
    random_words(25);

    set_config(16'd6554, 24'd65536, 20'd65536, 4'd1);
    random_words(30);

    // Last stretch runs with the start line held high, no gaps.
    set_config(16'd3277, 24'd131072, 20'd163840, 4'd4);
    no_gaps = 1'b1;
    random_words(45);

    start <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

/* quintic_joint_trajectory_sampler.f */
rtl/qjts_pkg.sv
rtl/qjts_regs.sv
rtl/qjts_mul.sv
rtl/qjts_div.sv
rtl/quintic_joint_trajectory_sampler.sv
rtl/qjts_check.sv
bench/qjts_checker.sv
bench/tb.sv
